// ----- src/tps_pkg.sv -----
// Shared types and constants for the triangle plane segment block.
`default_nettype none
package tps_pkg;
    localparam int IDX_W     = 31;
    localparam int CRD_W     = 32;
    localparam int NRM_W     = 18;
    localparam int OFF_W     = 50;
    localparam int PROD_W    = NRM_W + CRD_W;
    localparam int D_W       = PROD_W + 3;
    localparam int DEN_W     = D_W + 1;
    localparam int DX_W      = CRD_W + 1;
    localparam int Q_W       = CRD_W;
    localparam int NUM_W     = D_W + Q_W;
    localparam int SPLIT     = 27;
    localparam int LANES     = 4;
    localparam int VTX_BITS  = IDX_W + 3 * CRD_W;
    localparam int IN_W      = ((3 * VTX_BITS + 7) / 8) * 8;
    localparam int OUT_W     = 4 * CRD_W;
    localparam int ADDR_W    = 5;
    localparam int PDATA_W   = 64;
    localparam int REG_IDX_W = 2;
    localparam int QUEUE_DEPTH_DEF = 4;

    localparam logic [REG_IDX_W-1:0] REG_NORMAL_X = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_NORMAL_Y = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_NORMAL_Z = 2'd2;
    localparam logic [REG_IDX_W-1:0] REG_OFFSET   = 2'd3;

    localparam logic signed [NRM_W-1:0] NORMAL_Z_RST = 18'sd65536;

    typedef struct packed {
        logic signed [CRD_W-1:0] x0;
        logic signed [CRD_W-1:0] y0;
        logic signed [DX_W-1:0]  dx;
        logic signed [DX_W-1:0]  dy;
        logic signed [D_W-1:0]   d0;
        logic signed [DEN_W-1:0] den;
    } t_pt;

    typedef struct packed {
        logic cand;
        t_pt  p0;
        t_pt  p1;
    } t_job;
endpackage
`default_nettype wire

// ----- src/triangle_plane_segment.sv -----
// Top level of the triangle plane segment block with its register port.
// Usage:
//   One triangle per input word on s_tvalid/s_tready/s_tdata; one result word
//   per triangle on m_tvalid/m_tready/m_tdata/m_tuser, in input order.
//   m_tuser is the segment valid flag; with it low all points read zero.
//   The plane normal and offset are set through the APB port while idle.
// Pipeline: three front stages (products, distances, edge selection), one
//   queue write, then the back end: operand setup, split multiply, a 32-stage
//   restoring divider (one quotient bit per stage) and a final add and compare.
// Throughput: one triangle per cycle when nothing stalls; both the front end
//   and the divider pipeline take a new word every cycle unless held.
// Stall: the back end holds while the output word waits; the queue between
//   front and back absorbs short stalls, and s_tready drops once it is full.
// Reset: synchronous, active low; clears pipeline valids and the queue and
//   loads the normal (0, 0, 1.0) and a zero offset.
`default_nettype none
module triangle_plane_segment #(
    parameter int QUEUE_DEPTH = tps_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // a_index, a_x, a_y, a_z, b_index, b_x, b_y, b_z, c_index, c_x, c_y, c_z
    input  logic [tps_pkg::IN_W-1:0]        s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // start_x, start_y, end_x, end_y
    output logic [tps_pkg::OUT_W-1:0]       m_tdata,
    // segment_valid
    output logic                            m_tuser,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [tps_pkg::ADDR_W-1:0]      paddr,
    input  logic [tps_pkg::PDATA_W-1:0]     pwdata,
    output logic [tps_pkg::PDATA_W-1:0]     prdata,
    output logic                            pready
);
    import tps_pkg::*;

    logic signed [NRM_W-1:0] r_nx;
    logic signed [NRM_W-1:0] r_ny;
    logic signed [NRM_W-1:0] r_nz;
    logic signed [OFF_W-1:0] r_off;
    logic [REG_IDX_W-1:0]    w_reg;
    logic                    w_wr;
    logic                    w_push;
    logic                    w_full;
    logic                    w_pop;
    logic                    w_empty;
    t_job                    w_in_job;
    t_job                    w_out_job;

    assign pready = 1'b1;
    assign w_reg  = paddr[ADDR_W-1:3];
    assign w_wr   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nx  <= '0;
            r_ny  <= '0;
            r_nz  <= NORMAL_Z_RST;
            r_off <= '0;
        end else if (w_wr) begin
            unique case (w_reg)
                REG_NORMAL_X: r_nx  <= pwdata[NRM_W-1:0];
                REG_NORMAL_Y: r_ny  <= pwdata[NRM_W-1:0];
                REG_NORMAL_Z: r_nz  <= pwdata[NRM_W-1:0];
                REG_OFFSET:   r_off <= pwdata[OFF_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_reg)
            REG_NORMAL_X: prdata = {{(PDATA_W-NRM_W){1'b0}}, r_nx};
            REG_NORMAL_Y: prdata = {{(PDATA_W-NRM_W){1'b0}}, r_ny};
            REG_NORMAL_Z: prdata = {{(PDATA_W-NRM_W){1'b0}}, r_nz};
            REG_OFFSET:   prdata = {{(PDATA_W-OFF_W){1'b0}}, r_off};
            default:      prdata = '0;
        endcase
    end

    tps_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_tvalid),
        .o_ready (s_tready),
        .i_data  (s_tdata),
        .i_nx    (r_nx),
        .i_ny    (r_ny),
        .i_nz    (r_nz),
        .i_off   (r_off),
        .o_push  (w_push),
        .o_job   (w_in_job),
        .i_full  (w_full)
    );

    tps_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_in_job),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_empty (w_empty),
        .o_data  (w_out_job)
    );

    tps_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (!w_empty),
        .o_pop      (w_pop),
        .i_job      (w_out_job),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser)
    );
endmodule
`default_nettype wire

// ----- src/tps_front.sv -----
// Front end: plane distances, vertex classification and edge point selection.
`default_nettype none
module tps_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [tps_pkg::IN_W-1:0]            i_data,
    input  logic signed [tps_pkg::NRM_W-1:0]    i_nx,
    input  logic signed [tps_pkg::NRM_W-1:0]    i_ny,
    input  logic signed [tps_pkg::NRM_W-1:0]    i_nz,
    input  logic signed [tps_pkg::OFF_W-1:0]    i_off,
    output logic                                o_push,
    output tps_pkg::t_job                       o_job,
    input  logic                                i_full
);
    import tps_pkg::*;

    typedef struct packed {
        logic [IDX_W-1:0]        idx;
        logic signed [CRD_W-1:0] x;
        logic signed [CRD_W-1:0] y;
    } t_vtx;

    logic                     w_en;
    t_vtx                     w_v [3];
    logic signed [CRD_W-1:0]  w_z [3];
    logic signed [PROD_W-1:0] w_px [3];
    logic signed [PROD_W-1:0] w_py [3];
    logic signed [PROD_W-1:0] w_pz [3];

    logic                     r_f1_valid;
    t_vtx                     r_f1_v [3];
    logic signed [PROD_W-1:0] r_f1_px [3];
    logic signed [PROD_W-1:0] r_f1_py [3];
    logic signed [PROD_W-1:0] r_f1_pz [3];

    logic                     r_f2_valid;
    t_vtx                     r_f2_v [3];
    logic signed [D_W-1:0]    r_f2_d [3];

    logic                     r_f3_valid;
    t_job                     r_f3_job;

    logic [2:0]               w_pos;
    logic [2:0]               w_neg;
    logic [2:0]               w_zero;
    logic [2:0]               w_cross;
    logic [2:0]               w_onp;
    logic [2:0]               w_has;
    logic [2:0]               w_swap;
    t_vtx                     w_sv [3];
    t_vtx                     w_ev [3];
    logic signed [D_W-1:0]    w_sd [3];
    logic signed [D_W-1:0]    w_ed [3];
    t_pt                      w_cand [3];
    t_job                     n_f3_job;

    assign w_en    = !r_f3_valid || !i_full;
    assign o_ready = w_en;
    assign o_push  = r_f3_valid && !i_full;
    assign o_job   = r_f3_job;

    for (genvar i = 0; i < 3; i++) begin : g_vtx
        assign w_v[i].idx = i_data[i*VTX_BITS +: IDX_W];
        assign w_v[i].x   = $signed(i_data[i*VTX_BITS + IDX_W +: CRD_W]);
        assign w_v[i].y   = $signed(i_data[i*VTX_BITS + IDX_W + CRD_W +: CRD_W]);
        assign w_z[i]     = $signed(i_data[i*VTX_BITS + IDX_W + 2*CRD_W +: CRD_W]);
        assign w_px[i]    = PROD_W'(i_nx) * PROD_W'(w_v[i].x);
        assign w_py[i]    = PROD_W'(i_ny) * PROD_W'(w_v[i].y);
        assign w_pz[i]    = PROD_W'(i_nz) * PROD_W'(w_z[i]);
        assign w_zero[i]  = (r_f2_d[i] == '0);
        assign w_neg[i]   = r_f2_d[i][D_W-1];
        assign w_pos[i]   = !w_neg[i] && !w_zero[i];
    end

    for (genvar e = 0; e < 3; e++) begin : g_edge
        localparam int J = (e + 1) % 3;
        localparam int K = (e + 2) % 3;
        assign w_cross[e] = w_pos[e] ^ w_pos[J];
        assign w_onp[e]   = w_zero[e] && !w_zero[J] && ((w_pos[J] ^ w_pos[K]) || w_zero[K]);
        assign w_has[e]   = w_cross[e] || w_onp[e];
        assign w_swap[e]  = r_f2_v[J].idx < r_f2_v[e].idx;
        assign w_sv[e]    = w_swap[e] ? r_f2_v[J] : r_f2_v[e];
        assign w_ev[e]    = w_swap[e] ? r_f2_v[e] : r_f2_v[J];
        assign w_sd[e]    = w_swap[e] ? r_f2_d[J] : r_f2_d[e];
        assign w_ed[e]    = w_swap[e] ? r_f2_d[e] : r_f2_d[J];
        always_comb begin
            if (w_cross[e]) begin
                w_cand[e].x0  = w_sv[e].x;
                w_cand[e].y0  = w_sv[e].y;
                w_cand[e].dx  = DX_W'(w_ev[e].x) - DX_W'(w_sv[e].x);
                w_cand[e].dy  = DX_W'(w_ev[e].y) - DX_W'(w_sv[e].y);
                w_cand[e].d0  = w_sd[e];
                w_cand[e].den = DEN_W'(w_sd[e]) - DEN_W'(w_ed[e]);
            end else begin
                w_cand[e].x0  = r_f2_v[e].x;
                w_cand[e].y0  = r_f2_v[e].y;
                w_cand[e].dx  = '0;
                w_cand[e].dy  = '0;
                w_cand[e].d0  = '0;
                w_cand[e].den = DEN_W'(1);
            end
        end
    end

    always_comb begin
        n_f3_job.p0   = w_has[0] ? w_cand[0] : (w_has[1] ? w_cand[1] : w_cand[2]);
        n_f3_job.p1   = (w_has[0] && w_has[1]) ? w_cand[1] : w_cand[2];
        n_f3_job.cand = (|w_pos) && (|w_neg) &&
                        ((w_has[0] && w_has[1]) || (w_has[0] && w_has[2]) ||
                         (w_has[1] && w_has[2]));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_valid <= 1'b0;
            r_f2_valid <= 1'b0;
            r_f3_valid <= 1'b0;
        end else if (w_en) begin
            r_f1_valid <= i_valid;
            r_f2_valid <= r_f1_valid;
            r_f3_valid <= r_f2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                r_f1_v[i]  <= w_v[i];
                r_f1_px[i] <= w_px[i];
                r_f1_py[i] <= w_py[i];
                r_f1_pz[i] <= w_pz[i];
                r_f2_v[i]  <= r_f1_v[i];
                r_f2_d[i]  <= D_W'(r_f1_px[i]) + D_W'(r_f1_py[i]) + D_W'(r_f1_pz[i])
                              - D_W'(i_off);
            end
            r_f3_job <= n_f3_job;
        end
    end

    a_den_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_f3_valid && r_f3_job.cand) |-> (r_f3_job.p0.den != '0 && r_f3_job.p1.den != '0))
        else $error("segment point with zero denominator");
endmodule
`default_nettype wire

// ----- src/tps_fifo.sv -----
// Short job queue between the front end and the interpolation back end.
`default_nettype none
module tps_fifo #(
    parameter int DEPTH = tps_pkg::QUEUE_DEPTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  tps_pkg::t_job i_data,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_empty,
    output tps_pkg::t_job o_data
);
    import tps_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_job             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_cnt;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(DEPTH))
        else $error("queue count above depth");
    a_cnt_inc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> (r_cnt == $past(r_cnt) + 1'b1))
        else $error("queue count did not advance on push");
endmodule
`default_nettype wire

// ----- src/tps_back.sv -----
// Back end: edge interpolation by multiply and pipelined restoring division.
`default_nettype none
module tps_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_pop,
    input  tps_pkg::t_job               i_job,
    output logic                        o_m_tvalid,
    input  logic                        i_m_tready,
    output logic [tps_pkg::OUT_W-1:0]   o_m_tdata,
    output logic                        o_m_tuser
);
    import tps_pkg::*;

    localparam int PL_W = SPLIT + Q_W;
    localparam int PH_W = D_W - SPLIT + Q_W;

    logic                     b_en;
    logic signed [CRD_W-1:0]  w_x0 [LANES];
    logic signed [DX_W-1:0]   w_dx [LANES];
    logic signed [D_W-1:0]    w_d0 [LANES];
    logic signed [DEN_W-1:0]  w_den [LANES];

    logic                     r1_valid;
    logic                     r1_cand;
    logic signed [CRD_W-1:0]  r1_x0 [LANES];
    logic [D_W-1:0]           r1_ad0 [LANES];
    logic [Q_W-1:0]           r1_adx [LANES];
    logic [DEN_W-1:0]         r1_aden [LANES];
    logic                     r1_neg [LANES];

    logic                     r2_valid;
    logic                     r2_cand;
    logic signed [CRD_W-1:0]  r2_x0 [LANES];
    logic [PL_W-1:0]          r2_pl [LANES];
    logic [PH_W-1:0]          r2_ph [LANES];
    logic [DEN_W-1:0]         r2_aden [LANES];
    logic                     r2_neg [LANES];
    logic [NUM_W-1:0]         w_num [LANES];

    logic                     r_sv [Q_W+1];
    logic                     r_sc [Q_W+1];
    logic [DEN_W-1:0]         r_rem [LANES][Q_W+1];
    logic [Q_W-1:0]           r_low [LANES][Q_W+1];
    logic [Q_W-1:0]           r_q   [LANES][Q_W+1];
    logic [DEN_W-1:0]         r_den [LANES][Q_W+1];
    logic signed [CRD_W-1:0]  r_sx0 [LANES][Q_W+1];
    logic                     r_sneg [LANES][Q_W+1];
    logic [DEN_W:0]           w_t   [LANES][1:Q_W];
    logic [DEN_W:0]           w_sub [LANES][1:Q_W];

    logic                     r_r1_valid;
    logic                     r_r1_cand;
    logic [CRD_W-1:0]         r_res [LANES];
    logic                     w_seg;

    logic                     r_out_valid;
    logic                     r_out_seg;
    logic [OUT_W-1:0]         r_out_data;

    assign b_en       = !r_out_valid || i_m_tready;
    assign o_pop      = b_en && i_valid;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_seg;

    always_comb begin
        w_x0[0] = i_job.p0.x0;  w_dx[0] = i_job.p0.dx;
        w_x0[1] = i_job.p0.y0;  w_dx[1] = i_job.p0.dy;
        w_x0[2] = i_job.p1.x0;  w_dx[2] = i_job.p1.dx;
        w_x0[3] = i_job.p1.y0;  w_dx[3] = i_job.p1.dy;
        w_d0[0] = i_job.p0.d0;  w_den[0] = i_job.p0.den;
        w_d0[1] = i_job.p0.d0;  w_den[1] = i_job.p0.den;
        w_d0[2] = i_job.p1.d0;  w_den[2] = i_job.p1.den;
        w_d0[3] = i_job.p1.d0;  w_den[3] = i_job.p1.den;
    end

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            w_num[l] = NUM_W'(r2_pl[l]) + (NUM_W'(r2_ph[l]) << SPLIT);
            for (int s = 1; s <= Q_W; s++) begin
                w_t[l][s]   = {r_rem[l][s-1], r_low[l][s-1][Q_W-1]};
                w_sub[l][s] = w_t[l][s] - {1'b0, r_den[l][s-1]};
            end
        end
    end

    assign w_seg = r_r1_cand && ((r_res[0] != r_res[2]) || (r_res[1] != r_res[3]));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid    <= 1'b0;
            r2_valid    <= 1'b0;
            r_r1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            for (int s = 0; s <= Q_W; s++) begin
                r_sv[s] <= 1'b0;
            end
        end else if (b_en) begin
            r1_valid    <= i_valid;
            r2_valid    <= r1_valid;
            r_sv[0]     <= r2_valid;
            for (int s = 1; s <= Q_W; s++) begin
                r_sv[s] <= r_sv[s-1];
            end
            r_r1_valid  <= r_sv[Q_W];
            r_out_valid <= r_r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_en) begin
            r1_cand <= i_job.cand;
            r2_cand <= r1_cand;
            r_sc[0] <= r2_cand;
            for (int l = 0; l < LANES; l++) begin
                r1_x0[l]   <= w_x0[l];
                r1_ad0[l]  <= w_d0[l][D_W-1] ? D_W'(-w_d0[l]) : D_W'(w_d0[l]);
                r1_adx[l]  <= w_dx[l][DX_W-1] ? Q_W'(-w_dx[l]) : Q_W'(w_dx[l]);
                r1_aden[l] <= w_den[l][DEN_W-1] ? DEN_W'(-w_den[l]) : DEN_W'(w_den[l]);
                r1_neg[l]  <= w_d0[l][D_W-1] ^ w_dx[l][DX_W-1] ^ w_den[l][DEN_W-1];

                r2_x0[l]   <= r1_x0[l];
                r2_pl[l]   <= PL_W'(r1_ad0[l][SPLIT-1:0]) * PL_W'(r1_adx[l]);
                r2_ph[l]   <= PH_W'(r1_ad0[l][D_W-1:SPLIT]) * PH_W'(r1_adx[l]);
                r2_aden[l] <= r1_aden[l];
                r2_neg[l]  <= r1_neg[l];

                r_rem[l][0]  <= DEN_W'(w_num[l][NUM_W-1:Q_W]);
                r_low[l][0]  <= w_num[l][Q_W-1:0];
                r_q[l][0]    <= '0;
                r_den[l][0]  <= r2_aden[l];
                r_sx0[l][0]  <= r2_x0[l];
                r_sneg[l][0] <= r2_neg[l];
                for (int s = 1; s <= Q_W; s++) begin
                    r_rem[l][s]  <= w_sub[l][s][DEN_W] ? w_t[l][s][DEN_W-1:0]
                                                       : w_sub[l][s][DEN_W-1:0];
                    r_low[l][s]  <= r_low[l][s-1] << 1;
                    r_q[l][s]    <= {r_q[l][s-1][Q_W-2:0], !w_sub[l][s][DEN_W]};
                    r_den[l][s]  <= r_den[l][s-1];
                    r_sx0[l][s]  <= r_sx0[l][s-1];
                    r_sneg[l][s] <= r_sneg[l][s-1];
                end
                r_res[l] <= r_sneg[l][Q_W] ? CRD_W'(r_sx0[l][Q_W]) - r_q[l][Q_W]
                                           : CRD_W'(r_sx0[l][Q_W]) + r_q[l][Q_W];
            end
            for (int s = 1; s <= Q_W; s++) begin
                r_sc[s] <= r_sc[s-1];
            end
            r_r1_cand  <= r_sc[Q_W];
            r_out_seg  <= w_seg;
            r_out_data <= w_seg ? {r_res[3], r_res[2], r_res[1], r_res[0]} : '0;
        end
    end

    a_zero_when_none: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tuser) |-> (o_m_tdata == '0))
        else $error("no segment but nonzero points");
    a_points_differ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser) |->
        ((o_m_tdata[CRD_W-1:0] != o_m_tdata[3*CRD_W-1:2*CRD_W]) ||
         (o_m_tdata[2*CRD_W-1:CRD_W] != o_m_tdata[4*CRD_W-1:3*CRD_W])))
        else $error("segment with equal end points");
    a_rem_below_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sv[Q_W] |-> (r_rem[0][Q_W] < r_den[0][Q_W]))
        else $error("divider remainder out of range");
endmodule
`default_nettype wire

// ----- sim/tb_top.sv -----
// Testbench for triangle_plane_segment: streams triangles, predicts and checks segments.
`timescale 1ns / 100ps
module tb_top;
    import tps_pkg::*;

    typedef struct packed {
        logic                    valid;
        logic signed [CRD_W-1:0] sx;
        logic signed [CRD_W-1:0] sy;
        logic signed [CRD_W-1:0] ex;
        logic signed [CRD_W-1:0] ey;
    } t_seg;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [IN_W-1:0]     s_tdata = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [OUT_W-1:0]    m_tdata;
    logic                m_tuser;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [ADDR_W-1:0]   paddr = '0;
    logic [PDATA_W-1:0]  pwdata = '0;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    logic signed [NRM_W-1:0] nrm_x = '0;
    logic signed [NRM_W-1:0] nrm_y = '0;
    logic signed [NRM_W-1:0] nrm_z = NORMAL_Z_RST;
    logic signed [OFF_W-1:0] plane_off = '0;

    logic [IN_W-1:0] tri_queue[$];
    t_seg            seg_queue[$];
    int              mismatches = 0;
    int              seg_count = 0;
    int              valid_count = 0;
    int              cycles = 0;
    int              send_idle = 34;
    int              recv_idle = 79;
    longint          plane_z = 0;

    triangle_plane_segment dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #10 i_clk = ~i_clk;

    function automatic longint edge_point(longint a, longint b, longint d0, longint d1);
        logic signed [127:0] t0, t1, t2, q;
        longint dx, den, adx;
        dx = b - a;
        den = d0 - d1;
        if (den == 0 || d0 == 0 || dx == 0) return a;
        t0 = d0;
        t1 = dx;
        t2 = den;
        q = (t0 * t1) / t2;
        adx = dx < 0 ? -dx : dx;
        if (q > adx) q = adx;
        if (q < -adx) q = -adx;
        return a + longint'(q);
    endfunction

    function automatic t_seg slice_triangle(logic [IN_W-1:0] w);
        longint ix[3], vx[3], vy[3], d[3], px[2], py[2];
        int above, below, n, i, j, k, s, e, base;
        t_seg r;
        above = 0;
        below = 0;
        n = 0;
        r = '0;
        for (i = 0; i < 3; i++) begin
            base = i * VTX_BITS;
            ix[i] = w[base +: IDX_W];
            vx[i] = longint'($signed(w[base + IDX_W +: CRD_W]));
            vy[i] = longint'($signed(w[base + IDX_W + CRD_W +: CRD_W]));
            d[i] = longint'(nrm_x) * vx[i] + longint'(nrm_y) * vy[i]
                 + longint'(nrm_z) * longint'($signed(w[base + IDX_W + 2*CRD_W +: CRD_W]))
                 - longint'(plane_off);
            if (d[i] > 0) above++;
            else if (d[i] < 0) below++;
        end
        if (above > 0 && below > 0) begin
            for (i = 0; i < 3 && n < 2; i++) begin
                j = (i + 1) % 3;
                k = (i + 2) % 3;
                if ((d[i] > 0) != (d[j] > 0)) begin
                    s = i;
                    e = j;
                    if (ix[j] < ix[i]) begin
                        s = j;
                        e = i;
                    end
                    px[n] = edge_point(vx[s], vx[e], d[s], d[e]);
                    py[n] = edge_point(vy[s], vy[e], d[s], d[e]);
                    n++;
                end else if (d[i] == 0 && d[j] != 0) begin
                    if ((d[j] > 0) != (d[k] > 0) || d[k] == 0) begin
                        px[n] = vx[i];
                        py[n] = vy[i];
                        n++;
                    end
                end
            end
        end
        if (n == 2 && (px[0] != px[1] || py[0] != py[1])) begin
            r.valid = 1'b1;
            r.sx = px[0][CRD_W-1:0];
            r.sy = py[0][CRD_W-1:0];
            r.ex = px[1][CRD_W-1:0];
            r.ey = py[1][CRD_W-1:0];
        end
        return r;
    endfunction

    function automatic logic [IN_W-1:0] pack_triangle(longint ix[3], longint x[3],
                                                      longint y[3], longint z[3]);
        logic [IN_W-1:0] w;
        int base;
        w = '0;
        for (int i = 0; i < 3; i++) begin
            base = i * VTX_BITS;
            w[base +: IDX_W] = ix[i][IDX_W-1:0];
            w[base + IDX_W +: CRD_W] = x[i][CRD_W-1:0];
            w[base + IDX_W + CRD_W +: CRD_W] = y[i][CRD_W-1:0];
            w[base + IDX_W + 2*CRD_W +: CRD_W] = z[i][CRD_W-1:0];
        end
        return w;
    endfunction

    function automatic longint rand_coord(bit z_axis);
        case ($urandom_range(0, 3))
            0: return longint'($urandom_range(0, 16)) - 8;
            1: return z_axis ? plane_z : longint'($urandom_range(0, 2000)) - 1000;
            default: return longint'($signed($urandom()));
        endcase
    endfunction

    task automatic add_triangle(longint i0, longint i1, longint i2,
                                longint x0, longint y0, longint z0,
                                longint x1, longint y1, longint z1,
                                longint x2, longint y2, longint z2);
        longint ix[3], x[3], y[3], z[3];
        ix = '{i0, i1, i2};
        x = '{x0, x1, x2};
        y = '{y0, y1, y2};
        z = '{z0, z1, z2};
        tri_queue = {tri_queue, pack_triangle(ix, x, y, z)};
    endtask

    task automatic add_random(int count);
        longint ix[3], x[3], y[3], z[3];
        bit same;
        for (int n = 0; n < count; n++) begin
            same = ($urandom_range(0, 7) == 0);
            for (int i = 0; i < 3; i++) begin
                ix[i] = same ? 42 : longint'($urandom() & 32'h7fff_ffff);
                x[i] = rand_coord(1'b0);
                y[i] = rand_coord(1'b0);
                z[i] = rand_coord(1'b1);
            end
            tri_queue = {tri_queue, pack_triangle(ix, x, y, z)};
        end
    endtask

    task automatic reg_write(logic [REG_IDX_W-1:0] idx, longint value);
        @(posedge i_clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= ADDR_W'(idx) << 3;
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_NORMAL_X: nrm_x = value[NRM_W-1:0];
            REG_NORMAL_Y: nrm_y = value[NRM_W-1:0];
            REG_NORMAL_Z: nrm_z = value[NRM_W-1:0];
            REG_OFFSET:   plane_off = value[OFF_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_plane(longint nx, longint ny, longint nz, longint off);
        reg_write(REG_NORMAL_X, nx);
        reg_write(REG_NORMAL_Y, ny);
        reg_write(REG_NORMAL_Z, nz);
        reg_write(REG_OFFSET, off);
    endtask

    task automatic drain;
        while (tri_queue.size() != 0 || s_tvalid || seg_queue.size() != 0) @(posedge i_clk);
        repeat (45) @(posedge i_clk);
    endtask

    task automatic report_mismatch(string what, t_seg got, t_seg want);
        $display("segment %0d %s: got v=%0d (%0d,%0d)-(%0d,%0d) want v=%0d (%0d,%0d)-(%0d,%0d)",
                 seg_count, what, got.valid, got.sx, got.sy, got.ex, got.ey,
                 want.valid, want.sx, want.sy, want.ex, want.ey);
        mismatches++;
    endtask

    // driver
    always @(posedge i_clk) begin
        logic take;
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else begin
            take = s_tvalid && s_tready;
            if (take) seg_queue = {seg_queue, slice_triangle(s_tdata)};
            if (s_tvalid && !take) begin
                s_tvalid <= 1'b1;
            end else if (tri_queue.size() != 0 && $urandom_range(1, 100) > send_idle) begin
                s_tvalid <= 1'b1;
                s_tdata <= tri_queue.pop_front();
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_seg got, want;
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = {m_tuser, m_tdata[CRD_W-1:0], m_tdata[2*CRD_W-1:CRD_W],
                       m_tdata[3*CRD_W-1:2*CRD_W], m_tdata[4*CRD_W-1:3*CRD_W]};
                if (seg_queue.size() == 0) begin
                    report_mismatch("unexpected word", got, '0);
                end else begin
                    want = seg_queue.pop_front();
                    if (got.valid != want.valid) report_mismatch("valid flag", got, want);
                    if (got.sx != want.sx) report_mismatch("start_x", got, want);
                    if (got.sy != want.sy) report_mismatch("start_y", got, want);
                    if (got.ex != want.ex) report_mismatch("end_x", got, want);
                    if (got.ey != want.ey) report_mismatch("end_y", got, want);
                    if (want.valid) valid_count++;
                end
                seg_count++;
            end
            m_tready <= ($urandom_range(1, 100) > recv_idle);
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > 300000) begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset plane z = 0: directed cases
        add_triangle(0, 1, 2, 0, 0, 5, 10, 0, 6, 0, 10, 7);
        add_triangle(0, 1, 2, 0, 0, -5, 10, 0, -6, 0, 10, -7);
        add_triangle(0, 1, 2, 0, 0, 0, 10, 0, 0, 0, 10, 0);
        add_triangle(0, 1, 2, 0, 0, 4, 10, 0, -4, 0, 10, 4);
        add_triangle(2, 1, 0, 0, 0, 4, 10, 0, -4, 0, 10, 4);
        add_triangle(5, 5, 5, 0, 0, 3, 9, 7, -1, -6, 2, 8);
        add_triangle(0, 1, 2, 3, 3, 0, 10, 0, 5, 0, 10, -5);
        add_triangle(0, 1, 2, 3, 3, 0, 10, 0, 5, 0, 10, 5);
        add_triangle(0, 1, 2, 3, 3, 0, 8, 8, 0, 0, 10, -5);
        add_triangle(0, 1, 2, 3, 3, 0, 3, 3, 0, 0, 10, -5);
        add_triangle(0, 1, 2, 3, 3, 0, 9, 9, 5, 9, 9, -5);
        add_triangle(0, 1, 2, 1, 1, 1, 1, 1, -1, 5, 5, 1);
        add_triangle(32'h7fff_ffff, 0, 1, 32'h7fff_ffff, -32'h8000_0000, 32'h7fff_ffff,
                     -32'h8000_0000, 32'h7fff_ffff, -32'h8000_0000, 0, 0, 32'h7fff_ffff);
        add_triangle(0, 32'h7fff_ffff, 32'h7fff_fffe, -32'h8000_0000, -32'h8000_0000, -1,
                     32'h7fff_ffff, 32'h7fff_ffff, 1, -32'h8000_0000, 32'h7fff_ffff, 1);
        add_triangle(7, 3, 7, -100, 50, -32'h8000_0000, 100, -50, 32'h7fff_ffff, 3, 3, 0);
        add_random(130);
        drain();

        send_idle = 34;
        recv_idle = 79;
        set_plane(65536, -65536, -65536, 64'sh0001_ffff_ffff_ffff);
        add_random(60);
        drain();
        set_plane(-65536, 65536, 65536, -64'sh0002_0000_0000_0000);
        add_random(60);
        drain();

        send_idle = 79;
        recv_idle = 34;
        plane_z = 7;
        set_plane(0, 0, 65536, 7 * 65536);
        add_random(150);
        drain();
        set_plane(longint'($urandom_range(0, 131072)) - 65536,
                  longint'($urandom_range(0, 131072)) - 65536,
                  longint'($urandom_range(0, 131072)) - 65536,
                  longint'($signed($urandom())) * 1024);
        add_random(130);
        drain();

        send_idle = 0;
        recv_idle = 0;
        plane_z = 0;
        set_plane(-1, 3, 0, 0);
        add_random(120);
        drain();
        set_plane(40000, -25000, 12345, -1_000_000_000);
        add_random(130);
        drain();

        $display("Checked %0d segment words, %0d of them valid segments, over seven plane settings",
                 seg_count, valid_count);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule

// ----- files.f -----
src/tps_pkg.sv
src/tps_front.sv
src/tps_fifo.sv
src/tps_back.sv
src/triangle_plane_segment.sv
sim/tb_top.sv
